### hw/rtl/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

    // queue depth, entry count width and field widths
    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OCC_W    = 7;
    localparam int COORD_W  = 16;
    localparam int PRIO_W   = 32;

    // operation codes on the input word
    typedef enum logic [1:0] {
        KIND_PUSH  = 2'd0,
        KIND_POP   = 2'd1,
        KIND_PEEK  = 2'd2,
        KIND_CLEAR = 2'd3
    } t_kind;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // what every cell does in a cycle
    typedef enum logic [2:0] {
        CMD_HOLD = 3'b001,
        CMD_PUSH = 3'b010,
        CMD_POP  = 3'b100
    } t_cmd;

    // one stored entry
    typedef struct packed {
        logic signed [PRIO_W-1:0]  prio;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } t_entry;

    // control handed to one cell
    typedef struct packed {
        t_cmd cmd;
        logic first;
        logic occ;
    } t_cell_ctrl;

endpackage

### hw/rtl/spq_cell.sv
`timescale 1ns / 1ps

module spq_cell (
    input  logic                i_clk,
    input  spq_pkg::t_cell_ctrl i_ctrl,
    input  spq_pkg::t_entry     i_new,
    input  spq_pkg::t_entry     i_left,
    input  logic                i_left_ge,
    input  spq_pkg::t_entry     i_right,
    output spq_pkg::t_entry     o_entry,
    output logic                o_ge
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;
    logic            w_after;

    // new word sorts at or before this cell; head keeps equals ahead of it
    always_comb begin
        if (i_ctrl.first) begin
            w_after = r_entry.prio > i_new.prio;
        end else begin
            w_after = r_entry.prio >= i_new.prio;
        end
    end

    assign o_ge = !i_ctrl.occ || w_after;

    // next entry: keep, take the new word, or take a neighbor
    always_comb begin
        n_entry = r_entry;
        unique case (i_ctrl.cmd)
            spq_pkg::CMD_PUSH: begin
                if (o_ge && i_left_ge) begin
                    n_entry = i_left;
                end else if (o_ge) begin
                    n_entry = i_new;
                end
            end
            spq_pkg::CMD_POP: begin
                n_entry = i_right;
            end
            spq_pkg::CMD_HOLD: begin
                n_entry = r_entry;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

### hw/rtl/sorted_priority_queue.sv
`timescale 1ns / 1ps
// sorted priority queue of coordinate pairs, smallest priority at the head
// input channel: i_valid / o_stall carry one word (kind, x, y, priority);
//   kind push inserts, pop removes the head, peek reads it, clear empties
// output channel: o_valid / i_stall carry one result word per input word:
//   head x and y (pop or peek), status and occupancy after the operation
// throughput: one word per cycle while o_stall is low; every cell of the chain compares its own
//   entry with the new priority and shifts toward its neighbor in the same
//   cycle, so every push, pop, peek and clear is applied by the whole chain at once
// the result appears in the output register in the cycle after accept
// stall: while a result waits in the output register and i_stall is high,
//   o_stall is raised and no new word is taken; otherwise a word is taken
//   every cycle, also in the cycle the waiting result leaves
// reset (synchronous, active low): the queue is empty and no result is held;
//   entry contents need no clearing and are read only below the entry count
module sorted_priority_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic signed [15:0] i_item_x,
    input  logic signed [15:0] i_item_y,
    input  logic signed [31:0] i_priority_req,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [15:0] o_out_x,
    output logic signed [15:0] o_out_y,
    output logic [1:0]  o_status,
    output logic [6:0]  o_occupancy
);

    localparam int CAP = spq_pkg::CAPACITY;
    localparam int CW  = spq_pkg::CNT_W;
    localparam int OW  = spq_pkg::OCC_W;

    logic                      r_valid;
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             n_count;
    logic signed [15:0]        r_out_x;
    logic signed [15:0]        r_out_y;
    spq_pkg::t_status          r_status;
    spq_pkg::t_status          n_status;
    logic signed [15:0]        n_out_x;
    logic signed [15:0]        n_out_y;

    logic                      w_accept;
    logic                      w_full;
    logic                      w_empty;
    spq_pkg::t_kind            w_kind;
    spq_pkg::t_cmd             w_cmd;
    spq_pkg::t_entry           w_new;
    spq_pkg::t_entry           w_cells [CAP];
    logic                      w_ge    [CAP];
    logic [CW+OW-1:0]          w_occ_ext;

    assign o_stall  = r_valid && i_stall;
    assign w_accept = i_valid && !o_stall;
    assign w_kind   = spq_pkg::t_kind'(i_kind);
    assign w_full   = r_count == CW'(CAP);
    assign w_empty  = r_count == '0;

    assign w_new.prio = i_priority_req;
    assign w_new.y    = i_item_y;
    assign w_new.x    = i_item_x;

    // decode the word into a chain command, next count and result
    always_comb begin
        w_cmd    = spq_pkg::CMD_HOLD;
        n_count  = r_count;
        n_status = spq_pkg::ST_OK;
        n_out_x  = '0;
        n_out_y  = '0;
        unique case (w_kind)
            spq_pkg::KIND_PUSH: begin
                if (w_full) begin
                    n_status = spq_pkg::ST_FULL;
                end else begin
                    w_cmd   = spq_pkg::CMD_PUSH;
                    n_count = r_count + CW'(1);
                end
            end
            spq_pkg::KIND_POP: begin
                if (w_empty) begin
                    n_status = spq_pkg::ST_EMPTY;
                end else begin
                    w_cmd   = spq_pkg::CMD_POP;
                    n_count = r_count - CW'(1);
                    n_out_x = w_cells[0].x;
                    n_out_y = w_cells[0].y;
                end
            end
            spq_pkg::KIND_PEEK: begin
                if (w_empty) begin
                    n_status = spq_pkg::ST_EMPTY;
                end else begin
                    n_out_x = w_cells[0].x;
                    n_out_y = w_cells[0].y;
                end
            end
            spq_pkg::KIND_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // chain of cells, head at index 0
    for (genvar g = 0; g < CAP; g++) begin : g_cell
        spq_pkg::t_cell_ctrl w_ctrl;
        spq_pkg::t_entry     w_left;
        spq_pkg::t_entry     w_right;
        logic                w_left_ge;

        assign w_ctrl.cmd   = w_accept ? w_cmd : spq_pkg::CMD_HOLD;
        assign w_ctrl.first = (g == 0);
        assign w_ctrl.occ   = CW'(g) < r_count;

        if (g == 0) begin : g_head
            assign w_left    = w_new;
            assign w_left_ge = 1'b0;
        end else begin : g_body
            assign w_left    = w_cells[g-1];
            assign w_left_ge = w_ge[g-1];
        end

        if (g == CAP - 1) begin : g_tail
            assign w_right = w_cells[g];
        end else begin : g_mid
            assign w_right = w_cells[g+1];
        end

        spq_cell u_cell (
            .i_clk     (i_clk),
            .i_ctrl    (w_ctrl),
            .i_new     (w_new),
            .i_left    (w_left),
            .i_left_ge (w_left_ge),
            .i_right   (w_right),
            .o_entry   (w_cells[g]),
            .o_ge      (w_ge[g])
        );
    end

    // entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_accept) begin
            r_count <= n_count;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_x  <= n_out_x;
            r_out_y  <= n_out_y;
            r_status <= n_status;
        end
    end

    assign w_occ_ext   = {OW'(0), r_count};
    assign o_valid     = r_valid;
    assign o_out_x     = r_out_x;
    assign o_out_y     = r_out_y;
    assign o_status    = r_status;
    assign o_occupancy = w_occ_ext[OW-1:0];

    // count never passes the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAP))
        else $error("entry count above capacity");

    // a push into a queue with room grows it by one
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_kind == spq_pkg::KIND_PUSH && !w_full
        |=> r_count == $past(r_count) + CW'(1))
        else $error("push did not add an entry");

    // peek leaves the queue as it was
    a_peek_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_kind == spq_pkg::KIND_PEEK |=> $stable(r_count))
        else $error("peek changed the entry count");

    // an empty report goes with an empty queue
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_status == spq_pkg::ST_EMPTY |-> r_count == '0)
        else $error("empty status with entries held");

endmodule
